>>> rtl/gdcr_pkg.sv
`timescale 1ns / 1ps
package gdcr_pkg;
    localparam int MaxNodes = 1024;
    localparam int IdxW     = $clog2(MaxNodes);
    localparam int PosW     = 24;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 23;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_RUN    = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ROWS    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_REST    = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PASSES  = 2'd3;

    // one node record in memory: x, y, pinned, link mask
    localparam int NodeW = 2 * PosW + 1 + 4;

    typedef struct packed {
        logic [1:0]             func;
        logic [IdxW-1:0]        node_index;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic                   pinned;
        logic [3:0]             link_mask;
    } t_req;

    typedef struct packed {
        logic signed [PosW-1:0] out_x;
        logic signed [PosW-1:0] out_y;
        logic                   run_done;
    } t_rsp;

    typedef struct packed {
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } t_cfg;

    // relaxation unit handshake
    typedef struct packed {
        logic                   start;
        logic signed [PosW-1:0] xa;
        logic signed [PosW-1:0] ya;
        logic signed [PosW-1:0] xb;
        logic signed [PosW-1:0] yb;
        logic                   pa;
        logic                   pb;
        logic [22:0]            rest;
    } t_lnk_req;

    typedef struct packed {
        logic                   done;
        logic signed [PosW-1:0] xa;
        logic signed [PosW-1:0] ya;
        logic signed [PosW-1:0] xb;
        logic signed [PosW-1:0] yb;
    } t_lnk_rsp;
endpackage

>>> rtl/gdcr_if.sv
`timescale 1ns / 1ps
interface gdcr_req_if;
    logic              valid;
    logic              ready;
    gdcr_pkg::t_req    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gdcr_rsp_if;
    logic              valid;
    logic              ready;
    gdcr_pkg::t_rsp    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gdcr_cfg_if;
    logic              valid;
    logic              ready;
    gdcr_pkg::t_cfg    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/gdcr_ram.sv
`timescale 1ns / 1ps
module gdcr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/gdcr_link.sv
`timescale 1ns / 1ps
// Relax one link: square of distance, bit-serial root, bit-serial divide, round,
// saturating update. Each multiply is a full product formed in its own state.
module gdcr_link (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdcr_pkg::t_lnk_req  i_req,
    output gdcr_pkg::t_lnk_rsp  o_rsp
);
    import gdcr_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_MULX = 4'd4;
    localparam logic [3:0] S_DIVX = 4'd5;
    localparam logic [3:0] S_MULY = 4'd6;
    localparam logic [3:0] S_DIVY = 4'd7;
    localparam logic [3:0] S_UPD  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam int DW = PosW + 1;        // difference width
    localparam int SW = 2 * DW;          // sum of squares width, even for the root
    localparam int RW = (SW + 1) / 2;    // root width
    localparam int PW = DW + RW + 1;     // product width
    localparam int QW = RW + 3;          // denominator width

    logic [3:0]             r_state;
    logic signed [PosW-1:0] r_xa, r_ya, r_xb, r_yb;
    logic                   r_pa, r_pb;
    logic [22:0]            r_rest;
    logic [DW-1:0]          r_adx, r_ady;
    logic                   r_sdx, r_sdy;
    logic [SW-1:0]          r_sum;
    logic [SW-1:0]          r_rem;
    logic [RW-1:0]          r_root;
    logic [6:0]             r_cnt;
    logic signed [RW:0]     r_s;
    logic [PW-1:0]          r_num;
    logic [PW-1:0]          r_quo;
    logic [QW-1:0]          r_dr;
    logic [PW:0]            r_dvr;
    logic signed [PW:0]     r_mx, r_my;

    // restoring square root, one result bit per cycle
    logic [SW+1:0] w_trial;
    logic [SW+1:0] w_rs;
    assign w_rs    = {r_rem[SW-1:0], r_sum[SW-1 -: 2]} ;
    assign w_trial = {r_root, 2'b01};

    logic [QW-1:0] w_den;
    assign w_den = (r_pa || r_pb) ? {2'b0, r_root, 1'b0} : {1'b0, r_root, 2'b0};

    // long division step
    logic [PW:0] w_dsh;
    assign w_dsh = {r_dvr[PW-1:0], r_num[PW-1]};

    function automatic logic signed [PW:0] sat_apply(input logic signed [PosW-1:0] p,
                                                     input logic signed [PW:0] m,
                                                     input logic add);
        logic signed [PW+1:0] v;
        logic signed [PW+1:0] hi, lo;
        begin
            v  = add ? (PW+2)'(p) + (PW+2)'(m) : (PW+2)'(p) - (PW+2)'(m);
            hi = (PW+2)'({1'b0, {(PosW-1){1'b1}}});
            lo = -hi - 1;
            if (v > hi) v = hi;
            else if (v < lo) v = lo;
            sat_apply = v[PW:0];
        end
    endfunction

    logic signed [PW:0] w_nxa, w_nya, w_nxb, w_nyb;
    assign w_nxa = sat_apply(r_xa, r_mx, 1'b0);
    assign w_nya = sat_apply(r_ya, r_my, 1'b0);
    assign w_nxb = sat_apply(r_xb, r_mx, 1'b1);
    assign w_nyb = sat_apply(r_yb, r_my, 1'b1);

    logic signed [DW-1:0] w_dx, w_dy;
    assign w_dx = DW'(i_req.xa) - DW'(i_req.xb);
    assign w_dy = DW'(i_req.ya) - DW'(i_req.yb);

    logic [RW:0]        w_as;
    logic               w_ss;
    assign w_ss = r_s[RW];
    assign w_as = w_ss ? (RW+1)'(-r_s) : (RW+1)'(r_s);

    logic [PW-1:0] w_rnd;
    assign w_rnd = PW'(w_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_xa <= i_req.xa; r_ya <= i_req.ya;
                        r_xb <= i_req.xb; r_yb <= i_req.yb;
                        r_pa <= i_req.pa; r_pb <= i_req.pb;
                        r_rest <= i_req.rest;
                        r_sdx <= w_dx[DW-1];
                        r_sdy <= w_dy[DW-1];
                        r_adx <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
                        r_ady <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
                        r_state <= (i_req.pa && i_req.pb) ? S_DONE : S_SQX;
                    end
                end
                S_SQX: begin
                    r_sum <= SW'(r_adx * r_adx);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sum  <= r_sum + SW'(r_ady * r_ady);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= 7'(RW);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == '0) begin
                        if (r_root == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_s <= $signed({1'b0, r_root}) - (RW+1)'(r_rest);
                            r_state <= S_MULX;
                        end
                    end else begin
                        r_sum <= r_sum << 2;
                        r_cnt <= r_cnt - 7'd1;
                        if (w_rs >= w_trial) begin
                            r_rem  <= SW'(w_rs - w_trial);
                            r_root <= {r_root[RW-2:0], 1'b1};
                        end else begin
                            r_rem  <= SW'(w_rs);
                            r_root <= {r_root[RW-2:0], 1'b0};
                        end
                    end
                end
                S_MULX, S_MULY: begin
                    r_num <= PW'((r_state == S_MULX ? r_adx : r_ady) * w_as) + w_rnd;
                    r_dvr <= '0;
                    r_quo <= '0;
                    r_cnt <= 7'(PW);
                    r_state <= (r_state == S_MULX) ? S_DIVX : S_DIVY;
                end
                S_DIVX, S_DIVY: begin
                    if (r_cnt == '0) begin
                        if (r_state == S_DIVX) begin
                            r_mx <= (r_sdx ^ w_ss) ? -$signed({1'b0, r_quo})
                                                   : $signed({1'b0, r_quo});
                            r_state <= S_MULY;
                        end else begin
                            r_my <= (r_sdy ^ w_ss) ? -$signed({1'b0, r_quo})
                                                   : $signed({1'b0, r_quo});
                            r_state <= S_UPD;
                        end
                    end else begin
                        r_num <= r_num << 1;
                        r_cnt <= r_cnt - 7'd1;
                        if (w_dsh >= (PW+1)'(w_den)) begin
                            r_dvr <= w_dsh - (PW+1)'(w_den);
                            r_quo <= {r_quo[PW-2:0], 1'b1};
                        end else begin
                            r_dvr <= w_dsh;
                            r_quo <= {r_quo[PW-2:0], 1'b0};
                        end
                    end
                end
                S_UPD: begin
                    if (!r_pa) begin
                        r_xa <= w_nxa[PosW-1:0];
                        r_ya <= w_nya[PosW-1:0];
                    end
                    if (!r_pb) begin
                        r_xb <= w_nxb[PosW-1:0];
                        r_yb <= w_nyb[PosW-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.xa = r_xa;
    assign o_rsp.ya = r_ya;
    assign o_rsp.xb = r_xb;
    assign o_rsp.yb = r_yb;

    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done) else $error("done held");
    a_pin_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req.start && i_req.pa && i_req.pb) |=> o_rsp.done)
        else $error("pinned pair not skipped");
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQX) |-> $past(r_state) == S_IDLE) else $error("bad entry");
endmodule

>>> rtl/gdcr_seq.sv
`timescale 1ns / 1ps
// Sequencer: serves write and read requests, walks nodes and links for a run.
module gdcr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  gdcr_pkg::t_req      i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output gdcr_pkg::t_rsp      o_rsp,
    input  logic [10:0]         i_columns,
    input  logic [10:0]         i_rows,
    input  logic [22:0]         i_rest,
    input  logic [5:0]          i_passes
);
    import gdcr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDW   = 4'd1;
    localparam logic [3:0] S_NODE  = 4'd2;
    localparam logic [3:0] S_NRD   = 4'd3;
    localparam logic [3:0] S_LINK  = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BWT   = 4'd6;
    localparam logic [3:0] S_ARN   = 4'd7;
    localparam logic [3:0] S_RLX   = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;
    localparam logic [3:0] S_WBB   = 4'd10;
    localparam logic [3:0] S_CNT   = 4'd11;

    logic [3:0]       r_state;
    logic             r_ovalid;
    t_rsp             r_rsp;
    logic [IdxW:0]    r_count;
    logic [IdxW:0]    r_i;
    logic [10:0]      r_row;
    logic [5:0]       r_pass;
    logic [1:0]       r_lk;
    logic [IdxW-1:0]  r_b;
    logic [NodeW-1:0] r_a;
    logic [NodeW-1:0] r_bn;

    logic             w_we;
    logic [IdxW-1:0]  w_waddr, w_raddr;
    logic [NodeW-1:0] w_wdata, w_rdata;
    t_lnk_req         w_lreq;
    t_lnk_rsp         w_lrsp;

    gdcr_ram #(.Width(NodeW), .Depth(MaxNodes)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    gdcr_link u_link (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_lreq), .o_rsp(w_lrsp));

    logic w_acc;
    assign o_req_ready = (r_state == S_IDLE) && !r_ovalid;
    assign w_acc = i_req_valid && o_req_ready;

    // grid size, capped at memory depth
    logic [21:0] w_prod;
    logic [IdxW:0] w_cnt;
    assign w_prod = 22'(r_count);
    assign w_cnt  = r_count;

    logic [PosW-1:0] w_ax, w_ay, w_bx, w_by;
    assign w_ax = r_a[NodeW-1 -: PosW];
    assign w_ay = r_a[NodeW-PosW-1 -: PosW];
    assign w_bx = r_bn[NodeW-1 -: PosW];
    assign w_by = r_bn[NodeW-PosW-1 -: PosW];
    logic w_apin, w_bpin;
    assign w_apin = r_a[4];
    assign w_bpin = r_bn[4];
    logic [3:0] w_mask;
    assign w_mask = r_a[3:0];

    // neighbor for current link and whether it exists
    logic [IdxW+11:0] w_iw, w_rw, w_cw;
    logic             w_lv;
    logic [IdxW-1:0]  w_nb;
    always_comb begin
        w_iw = (IdxW+12)'(r_i);
        w_rw = (IdxW+12)'(i_rows);
        w_cw = (IdxW+12)'(w_cnt);
        w_lv = 1'b0;
        w_nb = '0;
        unique case (r_lk)
            2'd0: begin
                w_lv = w_mask[0] && (w_iw >= w_rw);
                w_nb = IdxW'(w_iw - w_rw);
            end
            2'd1: begin
                w_lv = w_mask[1] && (w_iw + w_rw < w_cw);
                w_nb = IdxW'(w_iw + w_rw);
            end
            2'd2: begin
                w_lv = w_mask[2] && (r_row != '0);
                w_nb = IdxW'(w_iw - 1);
            end
            default: begin
                w_lv = w_mask[3] && (12'(r_row) + 12'd1 < 12'(i_rows))
                       && (w_iw + 1 < w_cw);
                w_nb = IdxW'(w_iw + 1);
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i[IdxW-1:0];
        w_wdata = r_a;
        w_raddr = r_i[IdxW-1:0];
        if (w_acc && i_req.func == FUNC_WRITE) begin
            w_we    = 1'b1;
            w_waddr = i_req.node_index;
            w_wdata = {i_req.pos_x, i_req.pos_y, i_req.pinned, i_req.link_mask};
        end else if (r_state == S_WB) begin
            w_we    = 1'b1;
            w_waddr = r_i[IdxW-1:0];
            w_wdata = r_a;
        end else if (r_state == S_WBB) begin
            w_we    = 1'b1;
            w_waddr = r_b;
            w_wdata = r_bn;
        end
        // hold the neighbor address until its data is taken
        if (r_state == S_IDLE) w_raddr = i_req.node_index;
        else if (r_state == S_LINK) w_raddr = w_nb;
        else if (r_state == S_BRD) w_raddr = r_b;
    end

    assign w_lreq.start = (r_state == S_ARN);
    assign w_lreq.xa = w_ax;
    assign w_lreq.ya = w_ay;
    assign w_lreq.xb = w_bx;
    assign w_lreq.yb = w_by;
    assign w_lreq.pa = w_apin;
    assign w_lreq.pb = w_bpin;
    assign w_lreq.rest = i_rest;

    logic w_last_node;
    assign w_last_node = (r_i + 1'b1 == w_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_rsp_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_req.func == FUNC_READ) begin
                            r_state <= S_RDW;
                        end else if (i_req.func == FUNC_RUN) begin
                            r_count <= '0;
                            r_i     <= '0;
                            r_state <= S_CNT;
                        end
                    end
                end
                S_RDW: begin
                    r_rsp.out_x    <= w_rdata[NodeW-1 -: PosW];
                    r_rsp.out_y    <= w_rdata[NodeW-PosW-1 -: PosW];
                    r_rsp.run_done <= 1'b0;
                    r_ovalid       <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_CNT: begin
                    // columns*rows capped at depth, 11x11 product
                    if (22'(i_columns) * 22'(i_rows) > 22'(MaxNodes))
                        r_count <= (IdxW+1)'(MaxNodes);
                    else
                        r_count <= (IdxW+1)'(22'(i_columns) * 22'(i_rows));
                    r_pass <= '0;
                    r_i    <= '0;
                    r_row  <= '0;
                    r_state <= S_NODE;
                end
                S_NODE: begin
                    if (w_prod == '0 || i_rows == '0 || r_pass >= i_passes) begin
                        r_rsp.out_x    <= '0;
                        r_rsp.out_y    <= '0;
                        r_rsp.run_done <= 1'b1;
                        r_ovalid       <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        r_state <= S_NRD;
                    end
                end
                S_NRD: begin
                    r_a  <= w_rdata;
                    r_lk <= 2'd0;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    if (w_lv) begin
                        r_b <= w_nb;
                        r_state <= S_BRD;
                    end else if (r_lk == 2'd3) begin
                        r_state <= S_WB;
                    end else begin
                        r_lk <= r_lk + 2'd1;
                    end
                end
                S_BRD: r_state <= S_BWT;
                S_BWT: begin
                    r_bn <= w_rdata;
                    r_state <= S_ARN;
                end
                S_ARN: r_state <= S_RLX;
                S_RLX: begin
                    if (w_lrsp.done) begin
                        r_a[NodeW-1 -: 2*PosW]  <= {w_lrsp.xa, w_lrsp.ya};
                        r_bn[NodeW-1 -: 2*PosW] <= {w_lrsp.xb, w_lrsp.yb};
                        r_state <= S_WBB;
                    end
                end
                S_WBB: begin
                    if (r_lk == 2'd3) r_state <= S_WB;
                    else begin
                        r_lk <= r_lk + 2'd1;
                        r_state <= S_LINK;
                    end
                end
                S_WB: begin
                    if (w_last_node) begin
                        r_i    <= '0;
                        r_row  <= '0;
                        r_pass <= r_pass + 6'd1;
                    end else begin
                        r_i   <= r_i + 1'b1;
                        r_row <= (r_row + 11'd1 == i_rows) ? '0 : r_row + 11'd1;
                    end
                    r_state <= S_NODE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp_valid = r_ovalid;
    assign o_rsp = r_rsp;

    a_wb_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WBB) |-> $past(r_state) == S_RLX) else $error("write-back order");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_req_ready) else $error("request taken while busy");
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> r_i < r_count) else $error("node beyond grid");
endmodule

>>> rtl/grid_distance_constraint_relax_top.sv
`timescale 1ns / 1ps
// channel   dir  fields
// i_req     in   func, node_index, pos_x, pos_y, pinned, link_mask
// o_rsp     out  out_x, out_y, run_done
// i_cfg     in   index (0 columns, 1 rows, 2 rest_length, 3 passes), data
//
// A run walks every node once per pass; each live link goes through the bit-serial
// root and divide units.
// Reset clears control and sets config to its defaults; node memory is undefined until written.
// One request at a time; a new request waits until the response is taken.
module grid_distance_constraint_relax_top (
    input  logic i_clk,
    input  logic i_rst_n,
    gdcr_req_if.sink   i_req,
    gdcr_rsp_if.source o_rsp,
    gdcr_cfg_if.sink   i_cfg
);
    import gdcr_pkg::*;

    logic [10:0] r_columns, r_rows;
    logic [22:0] r_rest;
    logic [5:0]  r_passes;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 11'd32;
            r_rows    <= 11'd32;
            r_rest    <= 23'd32768;
            r_passes  <= 6'd2;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                REG_COLUMNS: r_columns <= i_cfg.payload.data[10:0];
                REG_ROWS:    r_rows    <= i_cfg.payload.data[10:0];
                REG_REST:    r_rest    <= i_cfg.payload.data;
                REG_PASSES:  r_passes  <= i_cfg.payload.data[5:0];
                default: ;
            endcase
        end
    end

    gdcr_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req.valid), .o_req_ready(i_req.ready), .i_req(i_req.payload),
        .o_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready), .o_rsp(o_rsp.payload),
        .i_columns(r_columns), .i_rows(r_rows), .i_rest(r_rest), .i_passes(r_passes)
    );
endmodule
